// ===== rtl/core/slot_allocator_dense_list_assert.svh =====
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shorthand for clocked checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_DENSE_LIST_ASSERT_SVH
`define SLOT_ALLOCATOR_DENSE_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAD_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sad_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Field widths, request and result codes, and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sad_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int TOP_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_ALLOC_AT = 2'd1,
    OP_FREE     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OCCUPIED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot;
    status_t            status;
    logic [IDX_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
    logic [TOP_W-1:0]   top;
  } res_t;

endpackage

// ===== rtl/core/slot_allocator_dense_list.sv =====
// ----------------------------------------------------------------------------
// Slot allocator with dense live list
// Allocates and frees slots, keeps a top mark and a packed list of live slots.
// ----------------------------------------------------------------------------
//  channel | signals                      | payload
//  --------+------------------------------+-----------------------------------
//  in      | in_valid / in_ready          | operation, slot_index
//  out     | out_valid / out_ready        | granted_slot, status, list_position,
//          |                              | live_count, top_slot
//
// One request at a time. Allocate scans one busy-map entry per cycle. Free
// walks one entry per cycle to lower the top mark, then one per cycle to
// find the slot in the live list, then makes one move. After rst, a
// clearing pass zeroes the busy map before in_ready rises. The output
// register holds a result while the next request is worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_allocator_dense_list #(
  parameter int SLOT_COUNT = sad_pkg::SLOT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sad_pkg::OP_W-1:0]           operation,
  input  logic [sad_pkg::IDX_W-1:0]          slot_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sad_pkg::IDX_W-1:0]          granted_slot,
  output logic [sad_pkg::STATUS_W-1:0]       status,
  output logic [sad_pkg::IDX_W-1:0]          list_position,
  output logic [sad_pkg::COUNT_W-1:0]        live_count,
  output logic signed [sad_pkg::TOP_W-1:0]   top_slot
);

  import sad_pkg::*;

  req_t req;
  res_t res;
  logic res_valid, res_ready;

  assign req.op  = op_t'(operation);
  assign req.idx = slot_index;

  sad_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Take a new result when the output register is empty or draining.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      granted_slot  <= res.slot;
      status        <= res.status;
      list_position <= res.pos;
      live_count    <= res.count;
      top_slot      <= res.top;
    end
  end

endmodule

// ===== rtl/core/sad_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = sad_pkg::SLOT_COUNT_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sad_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot allocator sequencer
// Busy map and dense list memories, one shared scan and compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_allocator_dense_list_assert.svh"

module sad_ctrl #(
  parameter int SLOT_COUNT = sad_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sad_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output sad_pkg::res_t res
);

  import sad_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int TW = SW + 1;
  localparam int XW = (SW > IDX_W) ? SW : IDX_W;
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int HW = (TW > TOP_W) ? TW : TOP_W;

  typedef enum logic [1:0] {
    SK_ALLOC,
    SK_LOWER,
    SK_LIST
  } scan_kind_t;

  state_t            state, state_next;
  scan_kind_t        kind, kind_next;
  logic [SW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     left, left_next;
  logic [SW-1:0]     chk, chk_next;
  logic              pend, pend_next;
  logic [SW-1:0]     clr_ptr, clr_ptr_next;
  logic [CW-1:0]     len, len_next;
  logic signed [TW-1:0] top, top_next;
  op_t               cur_op, cur_op_next;
  logic [SW-1:0]     idx, idx_next;
  logic [XW-1:0]     res_slot, res_slot_next;
  status_t           res_status, res_status_next;
  logic [SW-1:0]     res_pos, res_pos_next;

  logic              busy_we, busy_wdata, busy_rd;
  logic [SW-1:0]     busy_waddr, busy_raddr;
  logic              list_we;
  logic [SW-1:0]     list_waddr, list_wdata, list_raddr, list_rd;

  logic              req_oob;
  logic signed [TW-1:0] idx_s, top_inc;
  logic              match, hit, miss;

  logic [XW-1:0]     pos_x;
  logic [LW-1:0]     len_x;
  logic signed [HW-1:0] top_x;

  sad_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_busy (
    .clk  (clk),
    .we   (busy_we),
    .waddr(busy_waddr),
    .wdata(busy_wdata),
    .raddr(busy_raddr),
    .rdata(busy_rd)
  );

  sad_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_list (
    .clk  (clk),
    .we   (list_we),
    .waddr(list_waddr),
    .wdata(list_wdata),
    .raddr(list_raddr),
    .rdata(list_rd)
  );

  assign req_oob = (32'(req.idx) >= 32'(SLOT_COUNT));
  assign idx_s   = $signed({1'b0, idx});
  assign top_inc = top + TW'(1);

  // Shared compare: what counts as a hit depends on the running scan.
  always_comb begin
    unique case (kind)
      SK_ALLOC: match = !busy_rd;
      SK_LOWER: match = busy_rd;
      SK_LIST:  match = (list_rd == idx);
      default:  match = 1'b0;
    endcase
  end

  assign hit  = pend && match;
  assign miss = !pend && (left == '0);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign pos_x = XW'(res_pos);
  assign len_x = LW'(len);
  assign top_x = HW'(top);

  assign res.slot   = res_slot[IDX_W-1:0];
  assign res.status = res_status;
  assign res.pos    = pos_x[IDX_W-1:0];
  assign res.count  = len_x[COUNT_W-1:0];
  assign res.top    = top_x[TOP_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_ptr == SW'(SLOT_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            OP_ALLOC:    state_next = S_SCAN;
            OP_ALLOC_AT: state_next = req_oob ? S_DONE : S_LOOK;
            OP_FREE:     state_next = req_oob ? S_DONE : S_LOOK;
            OP_NONE:     state_next = S_IDLE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (cur_op == OP_FREE && busy_rd) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (hit || miss) begin
          unique case (kind)
            SK_ALLOC: state_next = S_DONE;
            SK_LOWER: state_next = S_SCAN;
            SK_LIST:  state_next = hit ? S_MOVE : S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_MOVE: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and datapath next values
  always_comb begin
    busy_we         = 1'b0;
    busy_waddr      = idx;
    busy_wdata      = 1'b0;
    busy_raddr      = ptr;
    list_we         = 1'b0;
    list_waddr      = SW'(len);
    list_wdata      = idx;
    list_raddr      = ptr;
    kind_next       = kind;
    ptr_next        = ptr;
    left_next       = left;
    chk_next        = chk;
    pend_next       = pend;
    clr_ptr_next    = clr_ptr;
    len_next        = len;
    top_next        = top;
    cur_op_next     = cur_op;
    idx_next        = idx;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    res_pos_next    = res_pos;

    unique case (state)
      S_CLEAR: begin
        busy_we      = 1'b1;
        busy_waddr   = clr_ptr;
        busy_wdata   = 1'b0;
        clr_ptr_next = clr_ptr + SW'(1);
      end
      S_IDLE: begin
        busy_raddr = SW'(req.idx);
        if (req_valid) begin
          cur_op_next     = req.op;
          idx_next        = SW'(req.idx);
          res_slot_next   = XW'(req.idx);
          res_status_next = ST_OK;
          res_pos_next    = '0;
          kind_next       = SK_ALLOC;
          ptr_next        = '0;
          left_next       = CW'($unsigned(top_inc));
          pend_next       = 1'b0;
          if (req.op == OP_ALLOC_AT && req_oob) begin
            res_status_next = ST_FULL;
          end
          if (req.op == OP_FREE && req_oob) begin
            res_status_next = ST_EMPTY;
          end
        end
      end
      S_LOOK: begin
        if (cur_op == OP_ALLOC_AT) begin
          if (busy_rd) begin
            res_status_next = ST_OCCUPIED;
          end else begin
            if (idx_s > top) begin
              top_next = idx_s;
            end
            busy_we      = 1'b1;
            busy_wdata   = 1'b1;
            list_we      = 1'b1;
            list_wdata   = idx;
            res_pos_next = SW'(len);
            len_next     = len + CW'(1);
          end
        end else begin
          if (!busy_rd) begin
            res_status_next = ST_EMPTY;
          end else begin
            busy_we    = 1'b1;
            busy_wdata = 1'b0;
            pend_next  = 1'b0;
            // Freeing a top slot above slot 1: walk down to the next busy one.
            if (idx_s == top && top > TW'(1)) begin
              kind_next = SK_LOWER;
              ptr_next  = SW'($unsigned(top - TW'(1)));
              left_next = CW'($unsigned(top - TW'(1)));
            end else begin
              if (idx_s == top) begin
                top_next = '0;
              end
              kind_next = SK_LIST;
              ptr_next  = '0;
              left_next = len;
            end
          end
        end
      end
      S_SCAN: begin
        // Keep one read in flight; check the previous one.
        if (left != '0) begin
          pend_next = 1'b1;
          chk_next  = ptr;
          ptr_next  = (kind == SK_LOWER) ? ptr - SW'(1) : ptr + SW'(1);
          left_next = left - CW'(1);
        end else begin
          pend_next = 1'b0;
        end
        if (hit) begin
          unique case (kind)
            SK_ALLOC: begin
              busy_we       = 1'b1;
              busy_waddr    = chk;
              busy_wdata    = 1'b1;
              list_we       = 1'b1;
              list_wdata    = chk;
              res_slot_next = XW'(chk);
              res_pos_next  = SW'(len);
              len_next      = len + CW'(1);
            end
            SK_LOWER: begin
              top_next  = $signed({1'b0, chk});
              kind_next = SK_LIST;
              ptr_next  = '0;
              left_next = len;
              pend_next = 1'b0;
            end
            SK_LIST: begin
              // Fetch the last entry to fill the hole.
              list_raddr   = SW'(len - CW'(1));
              res_pos_next = chk;
              len_next     = len - CW'(1);
            end
            default: ;
          endcase
        end else if (miss) begin
          unique case (kind)
            SK_ALLOC: begin
              if (top == TW'(SLOT_COUNT - 1)) begin
                res_status_next = ST_FULL;
                res_slot_next   = '0;
              end else begin
                top_next      = top_inc;
                busy_we       = 1'b1;
                busy_waddr    = SW'($unsigned(top_inc));
                busy_wdata    = 1'b1;
                list_we       = 1'b1;
                list_wdata    = SW'($unsigned(top_inc));
                res_slot_next = XW'(SW'($unsigned(top_inc)));
                res_pos_next  = SW'(len);
                len_next      = len + CW'(1);
              end
            end
            SK_LOWER: begin
              top_next  = '0;
              kind_next = SK_LIST;
              ptr_next  = '0;
              left_next = len;
              pend_next = 1'b0;
            end
            SK_LIST: begin
              res_pos_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_MOVE: begin
        list_we    = 1'b1;
        list_waddr = res_pos;
        list_wdata = list_rd;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_ptr <= '0;
      len     <= '0;
      top     <= '1;
      pend    <= 1'b0;
      left    <= '0;
      kind    <= SK_ALLOC;
    end else begin
      state   <= state_next;
      clr_ptr <= clr_ptr_next;
      len     <= len_next;
      top     <= top_next;
      pend    <= pend_next;
      left    <= left_next;
      kind    <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    chk        <= chk_next;
    cur_op     <= cur_op_next;
    idx        <= idx_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  `SAD_ASSERT_NEXT(a_leave_idle, req_valid && req_ready && req.op != OP_NONE, state != S_IDLE, "accepted request did not start")
  `SAD_ASSERT_HOLDS(a_top_range, 1'b1, top >= TW'(-1) && top <= TW'(SLOT_COUNT - 1), "top mark out of range")
  `SAD_ASSERT_HOLDS(a_len_range, 1'b1, len <= CW'(SLOT_COUNT), "list length beyond table size")
  `SAD_ASSERT_HOLDS(a_alloc_count, state == S_DONE && res_status == ST_OK && cur_op != OP_FREE, len != '0, "granted slot missing from list")

endmodule
